// File: design/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;
    localparam int MATCH_POS_W = 32;
    localparam int REPL_MAX    = 8;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES,
        REG_PATTERN_LENGTH,
        REG_REPLACEMENT_BYTES,
        REG_REPLACEMENT_LENGTH
    } t_reg_idx;

    // what a command starts with before any flushed window bytes
    typedef enum logic [1:0] {
        HEAD_NONE,
        HEAD_BYTE,
        HEAD_MATCH
    } t_head_kind;

    typedef struct packed {
        t_head_kind kind;
        logic       eos;
    } t_cmd_ctl;

endpackage

// File: design/sfr_cmd_fifo.sv
`timescale 1ns / 1ps
module sfr_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic             o_rd_valid,
    output logic [WIDTH-1:0] o_rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_fire    = i_wr_en && !o_full;
    assign rd_fire    = i_rd_en && o_rd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: design/sfr_front.sv
`timescale 1ns / 1ps
module sfr_front #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int POSITION_BITS     = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic [7:0]                             i_in_byte,
    input  logic                                   i_end_of_string,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]         i_pattern_bytes,
    input  logic [3:0]                             i_pattern_length,
    output logic                                   o_window_empty,
    output sfr_pkg::t_cmd_ctl                      o_ctl,
    output logic [7:0]                             o_head_byte,
    output logic [sfr_pkg::MATCH_POS_W-1:0]        o_match_pos,
    output logic [MAX_PATTERN_BYTES*8-1:0]         o_flush_data,
    output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] o_flush_cnt
);
    import sfr_pkg::*;

    localparam int MAX    = MAX_PATTERN_BYTES;
    localparam int FILL_W = $clog2(MAX + 1);

    logic [7:0]               r_win [MAX];
    logic [7:0]               n_win [MAX];
    logic [7:0]               w_new [MAX];
    logic [7:0]               win_after [MAX];
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] start_pos;
    logic [FILL_W-1:0]        len;
    logic [FILL_W-1:0]        slot;
    logic [FILL_W-1:0]        fill_inc;
    logic [FILL_W-1:0]        fill_after;
    logic                     window_full;
    logic                     hit;
    t_head_kind               kind;
    logic [7:0]               head_byte;

    always_comb begin
        len = (i_pattern_length > 4'(MAX)) ? FILL_W'(MAX) : FILL_W'(i_pattern_length);
        // a window that outgrew the pattern drops back to len-1 bytes
        slot     = (r_fill >= len) ? len - 1'b1 : r_fill;
        fill_inc = slot + 1'b1;
        for (int i = 0; i < MAX; i++) begin
            w_new[i] = (len != '0 && FILL_W'(i) == slot) ? i_in_byte : r_win[i];
        end
        window_full = (len != '0) && (fill_inc == len);
        hit = 1'b1;
        for (int i = 0; i < MAX; i++) begin
            if (FILL_W'(i) < len && w_new[i] != i_pattern_bytes[8*i +: 8]) begin
                hit = 1'b0;
            end
        end

        kind       = HEAD_NONE;
        head_byte  = i_in_byte;
        win_after  = w_new;
        fill_after = fill_inc;
        if (len == '0) begin
            kind       = HEAD_BYTE;
            win_after  = r_win;
            fill_after = r_fill;
        end else if (window_full && hit) begin
            kind       = HEAD_MATCH;
            fill_after = '0;
        end else if (window_full) begin
            // oldest byte leaves unmatched, the rest shift down
            kind      = HEAD_BYTE;
            head_byte = w_new[0];
            for (int i = 0; i < MAX - 1; i++) begin
                win_after[i] = w_new[i+1];
            end
            fill_after = fill_inc - 1'b1;
        end

        start_pos = r_pos - POSITION_BITS'(len) + 1'b1;

        n_win  = i_accept ? win_after : r_win;
        n_fill = r_fill;
        n_pos  = r_pos;
        if (i_accept) begin
            n_fill = i_end_of_string ? '0 : fill_after;
            n_pos  = r_pos + 1'b1;
        end
    end

    always_comb begin
        o_ctl.kind  = kind;
        o_ctl.eos   = i_end_of_string;
        o_head_byte = head_byte;
        o_match_pos = MATCH_POS_W'(start_pos);
        for (int i = 0; i < MAX; i++) begin
            o_flush_data[8*i +: 8] = win_after[i];
        end
        o_flush_cnt = i_end_of_string ? fill_after : '0;
    end

    assign o_window_empty = (r_fill == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else begin
            r_fill <= n_fill;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    a_eos_clears_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_string |=> r_fill == '0)
        else $error("window not cleared after end of string");

    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(MAX))
        else $error("window holds a full pattern between beats");

endmodule

// File: design/sfr_back.sv
`timescale 1ns / 1ps
module sfr_back #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cmd_valid,
    input  sfr_pkg::t_cmd_ctl                      i_ctl,
    input  logic [7:0]                             i_head_byte,
    input  logic [sfr_pkg::MATCH_POS_W-1:0]        i_match_pos,
    input  logic [MAX_PATTERN_BYTES*8-1:0]         i_flush_data,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] i_flush_cnt,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]         i_replacement_bytes,
    input  logic [3:0]                             i_replacement_length,
    output logic                                   o_cmd_pop,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_byte_valid,
    output logic                                   o_from_replacement,
    output logic                                   o_match_flag,
    output logic [sfr_pkg::MATCH_POS_W-1:0]        o_match_position,
    output logic                                   o_final_item
);
    import sfr_pkg::*;

    localparam int MAX   = MAX_PATTERN_BYTES;
    localparam int CNT_W = $clog2(REPL_MAX + MAX);
    localparam int IDX_W = (MAX > 1) ? $clog2(MAX) : 1;

    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] rlen;
    logic [CNT_W-1:0] head_n;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] flush_off;
    logic [IDX_W-1:0] fidx;
    logic             last;

    always_comb begin
        rlen = (i_replacement_length > 4'(REPL_MAX)) ? CNT_W'(REPL_MAX)
                                                     : CNT_W'(i_replacement_length);
        case (i_ctl.kind)
            HEAD_NONE:  head_n = '0;
            HEAD_BYTE:  head_n = CNT_W'(1);
            HEAD_MATCH: head_n = (rlen == '0) ? CNT_W'(1) : rlen;
            default:    head_n = '0;
        endcase
        total     = head_n + CNT_W'(i_flush_cnt);
        last      = (r_k == total - 1'b1);
        flush_off = r_k - head_n;
        fidx      = flush_off[IDX_W-1:0];
    end

    always_comb begin
        o_out_byte         = '0;
        o_byte_valid       = 1'b0;
        o_from_replacement = 1'b0;
        o_match_flag       = 1'b0;
        o_match_position   = '0;
        if (r_k < head_n) begin
            if (i_ctl.kind == HEAD_MATCH) begin
                if (rlen == '0) begin
                    // deleted match still reports its position
                    o_match_flag     = 1'b1;
                    o_match_position = i_match_pos;
                end else begin
                    o_out_byte         = i_replacement_bytes[8*r_k[2:0] +: 8];
                    o_byte_valid       = 1'b1;
                    o_from_replacement = 1'b1;
                    o_match_flag       = (r_k == '0);
                    o_match_position   = (r_k == '0) ? i_match_pos : '0;
                end
            end else begin
                o_out_byte   = i_head_byte;
                o_byte_valid = 1'b1;
            end
        end else begin
            o_out_byte   = i_flush_data[8*fidx +: 8];
            o_byte_valid = 1'b1;
        end
        o_final_item = i_ctl.eos && last;
    end

    assign o_empty   = !(i_cmd_valid && total != '0);
    assign o_cmd_pop = i_cmd_valid && (total == '0 || (i_pop && last));

    always_comb begin
        n_k = r_k;
        if (o_cmd_pop) begin
            n_k = '0;
        end else if (i_pop && !o_empty) begin
            n_k = r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else begin
            r_k <= n_k;
        end
    end

    a_k_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != '0 |-> i_cmd_valid)
        else $error("beat counter running without a command");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && total != '0 |-> r_k < total)
        else $error("beat counter past end of command");

endmodule

// File: design/stream_find_and_replace_core.sv
`timescale 1ns / 1ps
// each taken input beat becomes a command in the queue; the outputs show the queue head
// throughput: one input beat per cycle while the two-entry command queue has room
// output: one result beat per cycle while pop is high and empty is low; a match emits
// up to eight beats from one command; one with nothing to emit is popped without a beat
// reset: synchronous active low, clears config registers, window fill, position and queues
module stream_find_and_replace_core #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int POSITION_BITS     = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          i_in_byte,
    input  logic                                i_end_of_string,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          o_out_byte,
    output logic                                o_byte_valid,
    output logic                                o_from_replacement,
    output logic                                o_match_flag,
    output logic [sfr_pkg::MATCH_POS_W-1:0]     o_match_position,
    output logic                                o_final_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sfr_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import sfr_pkg::*;

    localparam int MAX    = MAX_PATTERN_BYTES;
    localparam int FILL_W = $clog2(MAX + 1);
    localparam int CTL_W  = $bits(t_cmd_ctl);
    localparam int CMD_W  = CTL_W + 8 + MATCH_POS_W + MAX * 8 + FILL_W;

    logic [CFG_DATA_W-1:0] r_pattern_bytes;
    logic [3:0]            r_pattern_length;
    logic [CFG_DATA_W-1:0] r_replacement_bytes;
    logic [3:0]            r_replacement_length;
    logic                  cfg_wr;
    t_reg_idx              reg_idx;

    logic                   accept;
    logic                   window_empty;
    t_cmd_ctl               f_ctl;
    logic [7:0]             f_head_byte;
    logic [MATCH_POS_W-1:0] f_match_pos;
    logic [MAX*8-1:0]       f_flush_data;
    logic [FILL_W-1:0]      f_flush_cnt;

    logic [CMD_W-1:0]       cmd_in;
    logic [CMD_W-1:0]       cmd_out;
    logic                   cmd_valid;
    logic                   cmd_pop;
    t_cmd_ctl               b_ctl;
    logic [7:0]             b_head_byte;
    logic [MATCH_POS_W-1:0] b_match_pos;
    logic [MAX*8-1:0]       b_flush_data;
    logic [FILL_W-1:0]      b_flush_cnt;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes      <= '0;
            r_pattern_length     <= '0;
            r_replacement_bytes  <= '0;
            r_replacement_length <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PATTERN_BYTES:      r_pattern_bytes <= pwdata;
                REG_PATTERN_LENGTH: begin
                    // length holds while the window carries bytes
                    if (window_empty) begin
                        r_pattern_length <= pwdata[3:0];
                    end
                end
                REG_REPLACEMENT_BYTES:  r_replacement_bytes <= pwdata;
                REG_REPLACEMENT_LENGTH: r_replacement_length <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PATTERN_BYTES:      prdata = r_pattern_bytes;
            REG_PATTERN_LENGTH:     prdata = CFG_DATA_W'(r_pattern_length);
            REG_REPLACEMENT_BYTES:  prdata = r_replacement_bytes;
            REG_REPLACEMENT_LENGTH: prdata = CFG_DATA_W'(r_replacement_length);
            default:                prdata = '0;
        endcase
    end

    assign accept = push && !full;

    sfr_front #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
        .POSITION_BITS    (POSITION_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_pattern_bytes (r_pattern_bytes),
        .i_pattern_length(r_pattern_length),
        .o_window_empty  (window_empty),
        .o_ctl           (f_ctl),
        .o_head_byte     (f_head_byte),
        .o_match_pos     (f_match_pos),
        .o_flush_data    (f_flush_data),
        .o_flush_cnt     (f_flush_cnt)
    );

    assign cmd_in = {f_ctl, f_head_byte, f_match_pos, f_flush_data, f_flush_cnt};

    sfr_cmd_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(2)
    ) u_cmd_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr_data (cmd_in),
        .o_full    (full),
        .i_rd_en   (cmd_pop),
        .o_rd_valid(cmd_valid),
        .o_rd_data (cmd_out)
    );

    assign {b_ctl, b_head_byte, b_match_pos, b_flush_data, b_flush_cnt} = cmd_out;

    sfr_back #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_valid         (cmd_valid),
        .i_ctl               (b_ctl),
        .i_head_byte         (b_head_byte),
        .i_match_pos         (b_match_pos),
        .i_flush_data        (b_flush_data),
        .i_flush_cnt         (b_flush_cnt),
        .i_replacement_bytes (r_replacement_bytes),
        .i_replacement_length(r_replacement_length),
        .o_cmd_pop           (cmd_pop),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_out_byte          (o_out_byte),
        .o_byte_valid        (o_byte_valid),
        .o_from_replacement  (o_from_replacement),
        .o_match_flag        (o_match_flag),
        .o_match_position    (o_match_position),
        .o_final_item        (o_final_item)
    );

    a_len_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && reg_idx == REG_PATTERN_LENGTH && !window_empty |=> $stable(r_pattern_length))
        else $error("pattern length changed with bytes in the window");

endmodule

// File: verif/stream_find_and_replace_core_tb.sv
`timescale 1ns / 1ps
module stream_find_and_replace_core_tb;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 24;

    // random phase flavors
    localparam int MODE_RANDOM = 0;
    localparam int MODE_STRESS = 1;
    localparam int MODE_LONGEST = 2;
    localparam int MODE_PASS = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]             data;
        logic                   valid;
        logic                   from_rep;
        logic                   match;
        logic [MATCH_POS_W-1:0] position;
        logic                   last;
    } t_out_beat;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    logic [7:0] i_in_byte;
    logic i_end_of_string;
    logic empty;
    logic pop;
    logic [7:0] o_out_byte;
    logic o_byte_valid;
    logic o_from_replacement;
    logic o_match_flag;
    logic [MATCH_POS_W-1:0] o_match_position;
    logic o_final_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    stream_find_and_replace_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_in_byte(i_in_byte),
        .i_end_of_string(i_end_of_string),
        .empty(empty),
        .pop(pop),
        .o_out_byte(o_out_byte),
        .o_byte_valid(o_byte_valid),
        .o_from_replacement(o_from_replacement),
        .o_match_flag(o_match_flag),
        .o_match_position(o_match_position),
        .o_final_item(o_final_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // stimulus waiting to be offered, and rewritten beats still owed by the block
    t_in_beat in_pending[$];
    t_out_beat expected_beats[$];

    // shadow of the block's registers and scan state
    logic [63:0] cfg_pat;
    logic [3:0] cfg_pat_len;
    logic [63:0] cfg_rep;
    logic [3:0] cfg_rep_len;
    logic [7:0] win_bytes [0:7];
    int win_fill;
    logic [MATCH_POS_W-1:0] pos_count;

    int err_count;
    int beat_count;
    int cycle_count;
    int gap_left;
    int burst_left;
    int rx_hold_left;
    int rx_style;
    int rx_tick;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_beat make_beat(input logic [7:0] data, input logic valid,
                                            input logic from_rep, input logic match,
                                            input logic [MATCH_POS_W-1:0] position);
        t_out_beat beat;
        beat.data = data;
        beat.valid = valid;
        beat.from_rep = from_rep;
        beat.match = match;
        beat.position = position;
        beat.last = 1'b0;
        return beat;
    endfunction

    // scan one input byte and queue the beats it produces
    function automatic void rewrite_byte(input logic [7:0] b, input logic eos);
        t_out_beat step_beats [0:15];
        int n;
        int len;
        int rlen;
        int i;
        logic [MATCH_POS_W-1:0] start;
        bit hit;
        n = 0;
        len = (cfg_pat_len > 4'd8) ? 8 : int'(cfg_pat_len);
        rlen = (cfg_rep_len > 4'd8) ? 8 : int'(cfg_rep_len);
        if (len == 0) begin
            step_beats[n] = make_beat(b, 1'b1, 1'b0, 1'b0, '0);
            n++;
        end else begin
            if (win_fill >= len) win_fill = len - 1;
            win_bytes[win_fill] = b;
            win_fill++;
            if (win_fill == len) begin
                hit = 1'b1;
                for (i = 0; i < len; i++) begin
                    if (win_bytes[i] != cfg_pat[8*i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    start = pos_count - MATCH_POS_W'(len - 1);
                    if (rlen == 0) begin
                        step_beats[n] = make_beat(8'h00, 1'b0, 1'b0, 1'b1, start);
                        n++;
                    end else begin
                        for (i = 0; i < rlen; i++) begin
                            step_beats[n] = make_beat(cfg_rep[8*i +: 8], 1'b1, 1'b1, i == 0,
                                                      (i == 0) ? start : '0);
                            n++;
                        end
                    end
                    win_fill = 0;
                end else begin
                    step_beats[n] = make_beat(win_bytes[0], 1'b1, 1'b0, 1'b0, '0);
                    n++;
                    for (i = 1; i < len; i++) win_bytes[i-1] = win_bytes[i];
                    win_fill--;
                end
            end
        end
        if (eos) begin
            for (i = 0; i < win_fill; i++) begin
                step_beats[n] = make_beat(win_bytes[i], 1'b1, 1'b0, 1'b0, '0);
                n++;
            end
            win_fill = 0;
            if (n > 0) step_beats[n-1].last = 1'b1;
        end
        pos_count++;
        for (i = 0; i < n; i++) expected_beats = {expected_beats, step_beats[i]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("beat %0d: %s got %0h expected %0h (cycle %0d)",
                 beat_count, what, got, want, cycle_count);
    endtask

    task automatic check_beat();
        t_out_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected, out_byte", 32'(o_out_byte), 32'h0);
        end else begin
            want = expected_beats.pop_front();
            if (o_out_byte !== want.data)
                report_mismatch("out_byte", 32'(o_out_byte), 32'(want.data));
            if (o_byte_valid !== want.valid)
                report_mismatch("byte_valid", 32'(o_byte_valid), 32'(want.valid));
            if (o_from_replacement !== want.from_rep)
                report_mismatch("from_replacement", 32'(o_from_replacement), 32'(want.from_rep));
            if (o_match_flag !== want.match)
                report_mismatch("match_flag", 32'(o_match_flag), 32'(want.match));
            if (o_match_position !== want.position)
                report_mismatch("match_position", 32'(o_match_position), 32'(want.position));
            if (o_final_item !== want.last)
                report_mismatch("final_item", 32'(o_final_item), 32'(want.last));
        end
        beat_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // monitor: results first, then the input beat taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_beat();
            if (push && !full) begin
                rewrite_byte(i_in_byte, i_end_of_string);
                void'(in_pending.pop_front());
            end
        end
    end

    // sender: bursts of random length, gaps between them, some bursts back to back
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (gap_left > 0) begin
            push <= 1'b0;
            gap_left--;
        end else if (in_pending.size() > 0) begin
            push <= 1'b1;
            i_in_byte <= in_pending[0].data;
            i_end_of_string <= in_pending[0].eos;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            push <= 1'b0;
        end
    end

    // receiver: stall style is redrawn periodically from its tick counter, long hold when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_hold_left > 0) begin
            pop <= 1'b0;
            rx_hold_left--;
        end else begin
            rx_tick++;
            if (rx_tick % 32 == 0) rx_style = $urandom_range(0, 3);
            case (rx_style)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= (rx_tick % 4 == 0);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_PATTERN_BYTES: cfg_pat = value;
            REG_PATTERN_LENGTH: begin
                // length only changes with an empty window
                if (win_fill == 0) cfg_pat_len = value[3:0];
            end
            REG_REPLACEMENT_BYTES: cfg_rep = value;
            REG_REPLACEMENT_LENGTH: cfg_rep_len = value[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic eos);
        t_in_beat beat;
        beat.data = data;
        beat.eos = eos;
        in_pending = {in_pending, beat};
    endtask

    task automatic wait_idle();
        while (in_pending.size() != 0 || expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_random_phase(input int n_items, input int mode);
        logic [7:0] alph [0:2];
        logic [7:0] seg [0:127];
        logic [63:0] pat;
        logic [63:0] rep;
        logic [3:0] plen;
        logic [3:0] rlen;
        int eff;
        int seg_n;
        int pieces;
        int piece;
        int k;
        int count;
        for (k = 0; k < 3; k++) alph[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < 8; k++) pat[8*k +: 8] = alph[$urandom_range(0, 2)];
        if ($urandom_range(0, 4) == 0) pat = {$urandom, $urandom};
        rep = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: plen = 4'd0;
            1: plen = 4'($urandom_range(9, 15));
            2, 3: plen = 4'($urandom_range(5, 8));
            default: plen = 4'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
            0: rlen = 4'd0;
            1: rlen = 4'($urandom_range(9, 15));
            default: rlen = 4'($urandom_range(1, 8));
        endcase
        case (mode)
            MODE_STRESS: begin
                plen = 4'd1;
                rlen = 4'd8;
            end
            MODE_LONGEST: begin
                plen = 4'd8;
                rlen = 4'd8;
            end
            MODE_PASS: begin
                plen = 4'd0;
                rlen = 4'd0;
            end
            default: ;
        endcase
        apb_write(REG_PATTERN_BYTES, pat);
        apb_write(REG_PATTERN_LENGTH, 64'(plen));
        apb_write(REG_REPLACEMENT_BYTES, rep);
        apb_write(REG_REPLACEMENT_LENGTH, 64'(rlen));
        eff = (plen > 4'd8) ? 8 : int'(plen);
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                // well-formed string: pattern copies, near misses and filler
                seg_n = 0;
                pieces = $urandom_range(1, 10);
                for (piece = 0; piece < pieces; piece++) begin
                    case ($urandom_range(0, 5))
                        0, 1: for (k = 0; k < eff; k++) begin
                            seg[seg_n] = pat[8*k +: 8];
                            seg_n++;
                        end
                        2: for (k = 0; k + 1 < eff; k++) begin
                            seg[seg_n] = pat[8*k +: 8];
                            seg_n++;
                        end
                        default: begin
                            seg[seg_n] = alph[$urandom_range(0, 2)];
                            seg_n++;
                        end
                    endcase
                end
                if (seg_n == 0) begin
                    seg[0] = alph[0];
                    seg_n = 1;
                end
                for (k = 0; k < seg_n; k++) queue_byte(seg[k], k == seg_n - 1);
                count += seg_n;
            end else begin
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                count++;
            end
        end
        // close the string so the window is empty for the next phase
        queue_byte(alph[$urandom_range(0, 2)], 1'b1);
    endtask

    initial begin
        int p;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_in_byte = 8'h00;
        i_end_of_string = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_pat = '0;
        cfg_pat_len = '0;
        cfg_rep = '0;
        cfg_rep_len = '0;
        for (p = 0; p < 8; p++) win_bytes[p] = 8'h00;
        win_fill = 0;
        pos_count = '0;
        err_count = 0;
        beat_count = 0;
        cycle_count = 0;
        gap_left = 0;
        burst_left = 0;
        rx_hold_left = 0;
        rx_style = 0;
        rx_tick = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pass-through with reset settings
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        // two-byte pattern deleted, two matches, the second closing the string
        apb_write(REG_PATTERN_BYTES, 64'h0000_0000_0000_FF00);
        apb_write(REG_PATTERN_LENGTH, 64'd2);
        apb_write(REG_REPLACEMENT_LENGTH, 64'd0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        // oversized lengths clamp to eight; near miss with a full flush, then a match
        apb_write(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(REG_PATTERN_LENGTH, 64'd15);
        apb_write(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        apb_write(REG_REPLACEMENT_LENGTH, 64'd12);
        for (p = 0; p < 7; p++) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        for (p = 0; p < 8; p++) queue_byte(8'hFF, p == 7);
        wait_idle();

        // length write while the window holds bytes is dropped
        apb_write(REG_PATTERN_LENGTH, 64'd3);
        apb_write(REG_REPLACEMENT_LENGTH, 64'd3);
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h79, 1'b0);
        wait_idle();
        apb_write(REG_PATTERN_LENGTH, 64'd1);
        queue_byte(8'h7A, 1'b1);
        wait_idle();

        for (p = 0; p < 8; p++) begin
            if (p == 2) begin
                // receiver holds off while the sender keeps going
                rx_hold_left = HOLD_CYCLES;
                load_random_phase(PHASE_ITEMS, MODE_STRESS);
            end else if (p == 5) begin
                load_random_phase(PHASE_ITEMS, MODE_LONGEST);
            end else if (p == 7) begin
                load_random_phase(PHASE_ITEMS, MODE_PASS);
            end else begin
                load_random_phase(PHASE_ITEMS, MODE_RANDOM);
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch("beats never delivered", 32'(expected_beats.size()), 32'h0);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
design/sfr_pkg.sv
design/sfr_cmd_fifo.sv
design/sfr_front.sv
design/sfr_back.sv
design/stream_find_and_replace_core.sv
verif/stream_find_and_replace_core_tb.sv
